[design/uartbe_pkg.sv]
package uartbe_pkg;

  localparam int unsigned RX_DEPTH_DEF = 64;
  localparam int unsigned TX_DEPTH_DEF = 64;

  localparam logic [2:0] REQ_RX      = 3'd0;
  localparam logic [2:0] REQ_TX_SLOT = 3'd1;
  localparam logic [2:0] REQ_PUT     = 3'd2;
  localparam logic [2:0] REQ_GET     = 3'd3;
  localparam logic [2:0] REQ_FREE    = 3'd4;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] BYTE_EMPTY = 8'hFF;

  typedef struct packed {
    logic capture;
    logic exec;
    logic push_lf;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_cr;
  } dp_stat_t;

endpackage

[design/uartbe_ctrl.sv]
module uartbe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  uartbe_pkg::dp_stat_t stat_i,
  output uartbe_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH_LF,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.exec     = (state_q == ST_EXEC);
    cmd_o.push_lf  = (state_q == ST_PUSH_LF);
    cmd_o.load_out = (state_q == ST_DONE);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = stat_i.need_cr ? ST_PUSH_LF : ST_DONE;
      end
      ST_PUSH_LF: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC) && !out_valid_q)
    else $error("accepted transaction did not start execution");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !out_valid_q)
    else $error("result register still occupied when a result completes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH_LF) |-> ($past(state_q) == ST_EXEC))
    else $error("second push without a preceding execute step");

endmodule

[design/uartbe_dpath.sv]
module uartbe_dpath #(
  parameter int unsigned RX_DEPTH = uartbe_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = uartbe_pkg::TX_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  uartbe_pkg::ctl_cmd_t cmd_i,
  output uartbe_pkg::dp_stat_t stat_o,
  input  logic [2:0]           req_type_i,
  input  logic [7:0]           data_byte_i,
  input  logic [7:0]           free_count_i,
  input  logic                 expand_newline_i,
  output logic [7:0]           read_byte_o,
  output logic                 read_valid_o,
  output logic [7:0]           tx_byte_o,
  output logic                 tx_valid_o,
  output logic                 tx_enable_o,
  output logic                 tx_empty_o,
  output logic                 rx_has_data_o,
  output logic [5:0]           rx_count_o,
  output logic [7:0]           line_count_o
);

  localparam int unsigned RXW = $clog2(RX_DEPTH);
  localparam int unsigned TXW = $clog2(TX_DEPTH);

  logic [2:0] req_q;
  logic [7:0] data_q;
  logic [7:0] nfree_q;
  logic       exp_q;

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_rd_q;
  logic [7:0] tx_rd_q;

  logic [RXW-1:0] rx_head_q, rx_head_d;
  logic [RXW-1:0] rx_fill_q, rx_fill_d;
  logic [7:0]     lines_q, lines_d;
  logic [TXW-1:0] tx_head_q, tx_head_d;
  logic [TXW-1:0] tx_tail_q, tx_tail_d;
  logic           irq_q, irq_d;
  logic           get_hit_q, get_hit_d;
  logic           get_miss_q, get_miss_d;
  logic           slot_hit_q, slot_hit_d;

  logic           rx_we;
  logic [RXW-1:0] rx_waddr;
  logic           tx_we;
  logic [TXW-1:0] tx_waddr;
  logic [7:0]     tx_wdata;
  logic [TXW-1:0] tail_inc;
  logic           push_en;
  logic [7:0]     push_byte;
  logic           drop_en;
  logic [7:0]     drop_n;
  logic           need_cr;
  logic           rx_full;
  logic [7:0]     fill8;

  function automatic logic [RXW-1:0] rx_add(input logic [RXW-1:0] p, input logic [7:0] n);
    logic [8:0] s;
    s = 9'(p) + 9'(n);
    if (s >= 9'(RX_DEPTH)) begin
      s = s - 9'(RX_DEPTH);
    end
    return s[RXW-1:0];
  endfunction

  function automatic logic [TXW-1:0] tx_inc(input logic [TXW-1:0] p);
    logic [TXW-1:0] r;
    if (p == TXW'(TX_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign need_cr        = (req_q == uartbe_pkg::REQ_PUT) && exp_q
                          && (data_q == uartbe_pkg::CHAR_LF);
  assign stat_o.need_cr = need_cr;
  assign rx_full        = 9'(rx_fill_q) >= 9'(RX_DEPTH - 1);
  assign fill8          = 8'(rx_fill_q);

  always_comb begin
    push_en    = 1'b0;
    push_byte  = data_q;
    drop_en    = 1'b0;
    drop_n     = nfree_q;
    rx_we      = 1'b0;
    rx_waddr   = rx_add(rx_head_q, fill8);
    lines_d    = lines_q;
    rx_fill_d  = rx_fill_q;
    get_hit_d  = get_hit_q;
    get_miss_d = get_miss_q;
    slot_hit_d = slot_hit_q;
    tx_head_d  = tx_head_q;
    irq_d      = irq_q;
    if (cmd_i.exec) begin
      get_hit_d  = 1'b0;
      get_miss_d = 1'b0;
      slot_hit_d = 1'b0;
      case (req_q)
        uartbe_pkg::REQ_RX: begin
          if (rx_full) begin
            lines_d = lines_q + 8'd1;
          end else begin
            rx_we     = 1'b1;
            rx_fill_d = rx_fill_q + 1'b1;
            if (data_q == uartbe_pkg::CHAR_LF) begin
              lines_d = lines_q + 8'd1;
            end
          end
        end
        uartbe_pkg::REQ_TX_SLOT: begin
          if (tx_head_q != tx_tail_q) begin
            slot_hit_d = 1'b1;
            tx_head_d  = tx_inc(tx_head_q);
          end else begin
            irq_d = 1'b0;
          end
        end
        uartbe_pkg::REQ_PUT: begin
          push_en   = 1'b1;
          push_byte = need_cr ? uartbe_pkg::CHAR_CR : data_q;
        end
        uartbe_pkg::REQ_GET: begin
          if (rx_fill_q == '0) begin
            get_miss_d = 1'b1;
          end else begin
            get_hit_d = 1'b1;
            drop_en   = 1'b1;
            drop_n    = 8'd1;
          end
        end
        uartbe_pkg::REQ_FREE: begin
          drop_en = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.push_lf) begin
      push_en   = 1'b1;
      push_byte = data_q;
    end
    rx_head_d = rx_head_q;
    if (drop_en) begin
      if (drop_n >= fill8) begin
        rx_fill_d = '0;
      end else begin
        rx_head_d = rx_add(rx_head_q, drop_n);
        rx_fill_d = rx_fill_q - RXW'(drop_n);
      end
    end
    tx_we     = push_en;
    tx_waddr  = tx_tail_q;
    tx_wdata  = push_byte;
    tail_inc  = tx_inc(tx_tail_q);
    tx_tail_d = tx_tail_q;
    if (push_en) begin
      tx_tail_d = tail_inc;
      irq_d     = 1'b1;
      if (tail_inc == tx_head_q) begin
        tx_head_d = tx_inc(tx_head_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= data_q;
    end
    rx_rd_q <= rx_mem[rx_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_waddr] <= tx_wdata;
    end
    tx_rd_q <= tx_mem[tx_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      data_q  <= data_byte_i;
      nfree_q <= free_count_i;
      exp_q   <= expand_newline_i;
    end
    if (cmd_i.load_out) begin
      read_byte_o   <= get_hit_q ? rx_rd_q : (get_miss_q ? uartbe_pkg::BYTE_EMPTY : 8'd0);
      read_valid_o  <= get_hit_q;
      tx_byte_o     <= slot_hit_q ? tx_rd_q : 8'd0;
      tx_valid_o    <= slot_hit_q;
      tx_enable_o   <= irq_q;
      tx_empty_o    <= (tx_head_q == tx_tail_q);
      rx_has_data_o <= (rx_fill_q != '0);
      rx_count_o    <= fill8[5:0];
      line_count_o  <= lines_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q  <= '0;
      rx_fill_q  <= '0;
      lines_q    <= '0;
      tx_head_q  <= '0;
      tx_tail_q  <= '0;
      irq_q      <= 1'b0;
      get_hit_q  <= 1'b0;
      get_miss_q <= 1'b0;
      slot_hit_q <= 1'b0;
    end else begin
      rx_head_q  <= rx_head_d;
      rx_fill_q  <= rx_fill_d;
      lines_q    <= lines_d;
      tx_head_q  <= tx_head_d;
      tx_tail_q  <= tx_tail_d;
      irq_q      <= irq_d;
      get_hit_q  <= get_hit_d;
      get_miss_q <= get_miss_d;
      slot_hit_q <= slot_hit_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (9'(rx_fill_q) <= 9'(RX_DEPTH - 1)) && (9'(rx_head_q) < 9'(RX_DEPTH)))
    else $error("receive store pointer or count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_we |=> (tx_head_q != tx_tail_q) && irq_q)
    else $error("transmit ring empty or disabled after a put");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> !(read_valid_o && tx_valid_o))
    else $error("get and transmitter slot results reported together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (req_q == uartbe_pkg::REQ_RX) && rx_full) |=> $stable(rx_fill_q))
    else $error("received byte stored into a full receive store");

endmodule

[design/uart_rx_tx_buffer_engine.sv]
// Byte buffer between a serial port and software. Each transaction carries one request
// (received byte, transmitter slot, put, get, free) and yields one result holding the
// returned bytes and the buffer status after the request. A request passes through capture,
// execute and the result register; a put of a line feed with carriage return expansion adds
// a second push step, as it writes the transmit ring twice through its single write port.
// The controller takes the next request once the current one is done and the result register
// is free or being drained. The receive store is a circular buffer with a front pointer,
// so a free of any count is a single pointer step; both stores are memories with
// registered reads.
module uart_rx_tx_buffer_engine #(
  parameter int unsigned RX_DEPTH = uartbe_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = uartbe_pkg::TX_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] free_count_i,
  input  logic       expand_newline_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o,
  output logic       read_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_valid_o,
  output logic       tx_enable_o,
  output logic       tx_empty_o,
  output logic       rx_has_data_o,
  output logic [5:0] rx_count_o,
  output logic [7:0] line_count_o
);

  uartbe_pkg::ctl_cmd_t cmd;
  uartbe_pkg::dp_stat_t stat;

  uartbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  uartbe_dpath #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (req_type_i),
    .data_byte_i     (data_byte_i),
    .free_count_i    (free_count_i),
    .expand_newline_i(expand_newline_i),
    .read_byte_o     (read_byte_o),
    .read_valid_o    (read_valid_o),
    .tx_byte_o       (tx_byte_o),
    .tx_valid_o      (tx_valid_o),
    .tx_enable_o     (tx_enable_o),
    .tx_empty_o      (tx_empty_o),
    .rx_has_data_o   (rx_has_data_o),
    .rx_count_o      (rx_count_o),
    .line_count_o    (line_count_o)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RXD          = uartbe_pkg::RX_DEPTH_DEF;
  localparam int unsigned TXD          = uartbe_pkg::TX_DEPTH_DEF;
  localparam logic [2:0]  REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  REQ_RSVD_LAST  = 3'd7;
  localparam int unsigned TARGET_REQS  = 1100;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       rd_ok;
    logic [7:0] tx_b;
    logic       tx_ok;
    logic       en;
    logic       tx_mt;
    logic       rx_nz;
    logic [5:0] rx_cnt;
    logic [7:0] lines;
  } status_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] req_type_i;
  logic [7:0] data_byte_i;
  logic [7:0] free_count_i;
  logic       expand_newline_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] read_byte_o;
  logic       read_valid_o;
  logic [7:0] tx_byte_o;
  logic       tx_valid_o;
  logic       tx_enable_o;
  logic       tx_empty_o;
  logic       rx_has_data_o;
  logic [5:0] rx_count_o;
  logic [7:0] line_count_o;

  logic [7:0]             rx_mem [RXD];
  int unsigned            rx_used = 0;
  logic [7:0]             lf_count = '0;
  logic [7:0]             tx_mem [TXD];
  logic [$clog2(TXD)-1:0] tx_rd = '0;
  logic [$clog2(TXD)-1:0] tx_wr = '0;
  logic                   tx_irq = 1'b0;

  status_t     status_q [$];
  bit          quiet;
  int unsigned out_hold;
  int unsigned idle_cycles;
  int unsigned err_count;
  int unsigned n_sent;
  int unsigned n_ignored;
  int unsigned n_checked;
  int unsigned rx_overflows;
  int unsigned tx_overwrites;

  uart_rx_tx_buffer_engine dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .data_byte_i      (data_byte_i),
    .free_count_i     (free_count_i),
    .expand_newline_i (expand_newline_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_byte_o      (read_byte_o),
    .read_valid_o     (read_valid_o),
    .tx_byte_o        (tx_byte_o),
    .tx_valid_o       (tx_valid_o),
    .tx_enable_o      (tx_enable_o),
    .tx_empty_o       (tx_empty_o),
    .rx_has_data_o    (rx_has_data_o),
    .rx_count_o       (rx_count_o),
    .line_count_o     (line_count_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void ring_push(logic [7:0] b);
    tx_mem[tx_wr] = b;
    tx_wr++;
    if (tx_wr == tx_rd) begin
      tx_rd++;
      tx_overwrites++;
    end
    tx_irq = 1'b1;
  endfunction

  function automatic void rx_discard(int unsigned n);
    if (rx_used == 0 || n >= rx_used) begin
      rx_used = 0;
    end else begin
      for (int unsigned k = 0; k + n < rx_used; k++) rx_mem[k] = rx_mem[k + n];
      rx_used -= n;
    end
  endfunction

  function automatic status_t apply_req(logic [2:0] rq, logic [7:0] data, logic [7:0] nfree,
                                        logic expand);
    status_t s;
    s = '0;
    case (rq)
      uartbe_pkg::REQ_RX: begin
        if (rx_used >= RXD - 1) begin
          lf_count++;
          rx_overflows++;
        end else begin
          rx_mem[rx_used] = data;
          rx_used++;
          if (data == uartbe_pkg::CHAR_LF) lf_count++;
        end
      end
      uartbe_pkg::REQ_TX_SLOT: begin
        if (tx_rd != tx_wr) begin
          s.tx_b  = tx_mem[tx_rd];
          s.tx_ok = 1'b1;
          tx_rd++;
        end else begin
          tx_irq = 1'b0;
        end
      end
      uartbe_pkg::REQ_PUT: begin
        if (expand && data == uartbe_pkg::CHAR_LF) ring_push(uartbe_pkg::CHAR_CR);
        ring_push(data);
      end
      uartbe_pkg::REQ_GET: begin
        if (rx_used == 0) begin
          s.rd_byte = uartbe_pkg::BYTE_EMPTY;
        end else begin
          s.rd_byte = rx_mem[0];
          s.rd_ok   = 1'b1;
          rx_discard(1);
        end
      end
      uartbe_pkg::REQ_FREE: rx_discard(nfree);
      default: ;
    endcase
    s.en     = tx_irq;
    s.tx_mt  = (tx_rd == tx_wr);
    s.rx_nz  = (rx_used != 0);
    s.rx_cnt = 6'(rx_used);
    s.lines  = lf_count;
    return s;
  endfunction

  task automatic send_req(input logic [2:0] rq, input logic [7:0] data, input logic [7:0] nfree,
                          input logic expand);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(9, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= rq;
    data_byte_i      <= data;
    free_count_i     <= nfree;
    expand_newline_i <= expand;
    do @(posedge clk_i); while (in_stall_o);
    status_q.push_back(apply_req(rq, data, nfree, expand));
    if (rq <= uartbe_pkg::REQ_FREE) n_sent++;
    else n_ignored++;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          $error("result with no transaction pending");
          err_count++;
        end else begin
          want = status_q.pop_front();
          check_field("read_byte", want.rd_byte, read_byte_o);
          check_field("read_valid", want.rd_ok, read_valid_o);
          check_field("tx_byte", want.tx_b, tx_byte_o);
          check_field("tx_valid", want.tx_ok, tx_valid_o);
          check_field("tx_enable", want.en, tx_enable_o);
          check_field("tx_empty", want.tx_mt, tx_empty_o);
          check_field("rx_has_data", want.rx_nz, rx_has_data_o);
          check_field("rx_count", want.rx_cnt, rx_count_o);
          check_field("line_count", want.lines, line_count_o);
          n_checked++;
        end
        out_hold = quiet ? 0 : $urandom_range(9, 0);
      end else if (out_valid_o && out_hold != 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7, 0))
      0, 1:    return uartbe_pkg::CHAR_LF;
      2:       return uartbe_pkg::CHAR_CR;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_free();
    if ($urandom_range(3, 0) == 0) return 8'($urandom);
    return 8'($urandom_range(rx_used + 2, 0));
  endfunction

  task automatic test_empty_store();
    send_req(uartbe_pkg::REQ_GET, 8'h00, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_FREE, 8'h00, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_FREE, 8'h00, 8'h05, 1'b0);
    send_req(uartbe_pkg::REQ_TX_SLOT, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_receive_path();
    send_req(uartbe_pkg::REQ_RX, 8'h00, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_RX, 8'hFF, 8'hFF, 1'b1);
    send_req(uartbe_pkg::REQ_RX, uartbe_pkg::CHAR_LF, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_GET, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_transmit_path();
    send_req(uartbe_pkg::REQ_PUT, 8'h41, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_PUT, uartbe_pkg::CHAR_LF, 8'h00, 1'b1);
    send_req(uartbe_pkg::REQ_PUT, uartbe_pkg::CHAR_LF, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_PUT, 8'hFF, 8'hFF, 1'b1);
    repeat (6) send_req(uartbe_pkg::REQ_TX_SLOT, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_get_and_free();
    send_req(uartbe_pkg::REQ_RX, 8'h11, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_RX, 8'h22, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_RX, 8'h33, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_FREE, 8'h00, 8'h00, 1'b0);
    send_req(uartbe_pkg::REQ_FREE, 8'h00, 8'h01, 1'b0);
    send_req(uartbe_pkg::REQ_FREE, 8'h00, 8'hFF, 1'b0);
  endtask

  task automatic test_reserved_codes();
    for (int unsigned c = REQ_RSVD_FIRST; c <= REQ_RSVD_LAST; c++)
      send_req(3'(c), 8'hFF, 8'hFF, 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned kind;
    int unsigned len;
    logic [2:0]  rq;
    while (n_sent < TARGET_REQS) begin
      quiet = ($urandom_range(3, 0) == 0);
      kind  = $urandom_range(9, 0);
      case (kind)
        3: begin
          len = $urandom_range(70, 10);
          repeat (len) send_req(uartbe_pkg::REQ_RX, rand_byte(), 8'($urandom), 1'($urandom));
        end
        4: begin
          len = $urandom_range(20, 1);
          repeat (len) send_req(uartbe_pkg::REQ_GET, 8'($urandom), 8'($urandom), 1'($urandom));
          send_req(uartbe_pkg::REQ_FREE, 8'($urandom), rand_free(), 1'($urandom));
        end
        5: begin
          len = $urandom_range(70, 10);
          repeat (len) send_req(uartbe_pkg::REQ_PUT, rand_byte(), 8'($urandom), 1'($urandom));
          len = int'(6'(tx_wr - tx_rd)) + 1;
          repeat (len) send_req(uartbe_pkg::REQ_TX_SLOT, 8'($urandom), 8'($urandom),
                                1'($urandom));
        end
        6: begin
          len = $urandom_range(5, 1);
          repeat (len) send_req(uartbe_pkg::REQ_FREE, 8'($urandom), rand_free(), 1'($urandom));
        end
        7: begin
          len = $urandom_range(4, 1);
          repeat (len) begin
            rq = 3'($urandom_range(REQ_RSVD_LAST, REQ_RSVD_FIRST));
            send_req(rq, 8'($urandom), 8'($urandom), 1'($urandom));
          end
          send_req(uartbe_pkg::REQ_TX_SLOT, 8'($urandom), 8'($urandom), 1'($urandom));
        end
        default: begin
          len = $urandom_range(30, 5);
          repeat (len) begin
            rq = 3'($urandom_range(uartbe_pkg::REQ_FREE, uartbe_pkg::REQ_RX));
            send_req(rq, rand_byte(), rand_free(), 1'($urandom));
          end
        end
      endcase
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    req_type_i       = uartbe_pkg::REQ_RX;
    data_byte_i      = 8'h00;
    free_count_i     = 8'h00;
    expand_newline_i = 1'b0;
    out_stall_i      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_store();
    test_receive_path();
    test_transmit_path();
    test_get_and_free();
    test_reserved_codes();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d requests and %0d reserved codes sent, %0d results compared",
             n_sent, n_ignored, n_checked);
    $display("tb: %0d receive drops when full, %0d transmit bytes overwritten",
             rx_overflows, tx_overwrites);
    if (err_count == 0 && status_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/uartbe_pkg.sv
design/uartbe_ctrl.sv
design/uartbe_dpath.sv
design/uart_rx_tx_buffer_engine.sv
tb/sv/tb.sv
